// ===== hdl/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, constants and payload types of the capsule clearance check.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int RAD_W   = 28;
    localparam int CLR_W   = 24;
    localparam int DIST_W  = 33;
    localparam int GAP_W   = 33;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int LEN_W   = 2 * COORD_W + 1;
    localparam int SQ_W    = LEN_W + 2;

    // lane latency beyond the divider stages: mul, sum, select/mul, offset,
    // square, sum, then one stage per root bit
    localparam int LANE_FIXED = 6 + DIST_W;

    localparam logic [CLR_W-1:0] GLOBAL_RESET = CLR_W'(200000);

    typedef struct packed {
        logic signed [DIFF_W-1:0] d1_x;
        logic signed [DIFF_W-1:0] d1_y;
        logic signed [DIFF_W-1:0] d2_x;
        logic signed [DIFF_W-1:0] d2_y;
        logic signed [DIFF_W-1:0] w0_x;
        logic signed [DIFF_W-1:0] w0_y;
        logic signed [DIFF_W-1:0] w1_x;
        logic signed [DIFF_W-1:0] w1_y;
        logic signed [DIFF_W-1:0] w3_x;
        logic signed [DIFF_W-1:0] w3_y;
        logic [RAD_W-1:0]         r1;
        logic [RAD_W-1:0]         r2;
        logic [CLR_W-1:0]         eff;
    } t_item;

    typedef struct packed {
        logic [CLR_W-1:0] eff;
        logic [RAD_W-1:0] r1;
        logic [RAD_W-1:0] r2;
        logic             crossed;
    } t_side;

    typedef struct packed {
        logic             violation;
        logic [GAP_W-1:0] gap;
        logic [CLR_W-1:0] eff;
    } t_result;

endpackage

// ===== hdl/csc_fifo2.sv =====
// ----------------------------------------------------------------------------
// csc_fifo2
// Two-entry queue; sustains one transfer per cycle on both sides, but a push is refused while full, even beside a pop.
// ----------------------------------------------------------------------------
module csc_fifo2 #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr && !rd) begin
                r_count <= r_count + 2'd1;
            end else if (rd && !wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/csc_front.sv =====
// ----------------------------------------------------------------------------
// csc_front
// Input stage: takes a capsule pair, forms edge vectors, picks the clearance.
// ----------------------------------------------------------------------------
module csc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [csc_pkg::CLR_W-1:0]           i_cfg_wdata,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_a1_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_a1_y,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_b1_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_b1_y,
    input  logic [csc_pkg::RAD_W-1:0]           i_r1,
    input  logic [csc_pkg::CLR_W-1:0]           i_c1,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_a2_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_a2_y,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_b2_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_b2_y,
    input  logic [csc_pkg::RAD_W-1:0]           i_r2,
    input  logic [csc_pkg::CLR_W-1:0]           i_c2,
    output csc_pkg::t_item                      o_item,
    output logic                                o_item_valid,
    input  logic                                i_item_full
);

    logic [csc_pkg::CLR_W-1:0] r_glob;
    logic                      r_fv;
    csc_pkg::t_item            r_item;
    csc_pkg::t_item            n_item;
    logic [csc_pkg::CLR_W-1:0] eff01;
    logic                      load;

    function automatic logic signed [csc_pkg::DIFF_W-1:0] sub(
        input logic signed [csc_pkg::COORD_W-1:0] a,
        input logic signed [csc_pkg::COORD_W-1:0] b
    );
        return csc_pkg::DIFF_W'(a) - csc_pkg::DIFF_W'(b);
    endfunction

    assign o_full       = r_fv && i_item_full;
    assign load         = i_push && !o_full;
    assign o_item_valid = r_fv;
    assign o_item       = r_item;

    always_comb begin
        eff01       = (i_c1 > r_glob) ? i_c1 : r_glob;
        n_item.eff  = (i_c2 > eff01) ? i_c2 : eff01;
        n_item.d1_x = sub(i_b1_x, i_a1_x);
        n_item.d1_y = sub(i_b1_y, i_a1_y);
        n_item.d2_x = sub(i_b2_x, i_a2_x);
        n_item.d2_y = sub(i_b2_y, i_a2_y);
        n_item.w0_x = sub(i_a1_x, i_a2_x);
        n_item.w0_y = sub(i_a1_y, i_a2_y);
        n_item.w1_x = sub(i_b1_x, i_a2_x);
        n_item.w1_y = sub(i_b1_y, i_a2_y);
        n_item.w3_x = sub(i_b2_x, i_a1_x);
        n_item.w3_y = sub(i_b2_y, i_a1_y);
        n_item.r1   = i_r1;
        n_item.r2   = i_r2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob <= csc_pkg::GLOBAL_RESET;
            r_fv   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_glob <= i_cfg_wdata;
            end
            if (load) begin
                r_fv <= 1'b1;
            end else if (!i_item_full) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/csc_lane.sv =====
// ----------------------------------------------------------------------------
// csc_lane
// Pipelined point-to-segment distance: projection, restoring divide for t,
// projected offset, squared error and a bit-per-stage floor square root.
// ----------------------------------------------------------------------------
module csc_lane #(
    parameter int T_FRACTION_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [csc_pkg::DIFF_W-1:0]  i_w_x,
    input  logic signed [csc_pkg::DIFF_W-1:0]  i_w_y,
    input  logic signed [csc_pkg::DIFF_W-1:0]  i_d_x,
    input  logic signed [csc_pkg::DIFF_W-1:0]  i_d_y,
    output logic [csc_pkg::DIST_W-1:0]         o_dist
);

    localparam int TFB    = T_FRACTION_BITS;
    localparam int TW     = TFB + 1;
    localparam int DW     = csc_pkg::DIFF_W;
    localparam int CW     = csc_pkg::COORD_W;
    localparam int PW     = csc_pkg::PROD_W;
    localparam int LW     = csc_pkg::LEN_W;
    localparam int SW     = csc_pkg::SQ_W;
    localparam int RW     = csc_pkg::DIST_W;
    localparam int PP_W   = CW + TW;

    typedef struct packed {
        logic signed [DW-1:0] w_x;
        logic signed [DW-1:0] w_y;
        logic signed [DW-1:0] d_x;
        logic signed [DW-1:0] d_y;
        logic                 zero;
        logic                 one;
    } t_ctx;

    function automatic logic [CW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] a;
        a = v[DW-1] ? DW'(-v) : DW'(v);
        return a[CW-1:0];
    endfunction

    // products of the projection
    logic signed [PW-1:0] r1_wd_x, r1_wd_y, r1_dd_x, r1_dd_y;
    t_ctx                 r1_ctx;

    logic [LW-1:0]        n_len;
    logic signed [PW-1:0] n_dot;
    logic                 n_zero;
    logic                 n_one;

    t_ctx                 r_dctx [TFB+1];
    logic [LW-1:0]        r_dlen [TFB+1];
    logic [LW-1:0]        r_drem [TFB+1];
    logic [TFB-1:0]       r_dq   [TFB+1];

    logic [TW-1:0]        n_t;
    logic [PP_W-1:0]      r_p_x, r_p_y;
    t_ctx                 r_pctx;
    logic [CW-1:0]        off_x, off_y;
    logic signed [DW:0]   n_ex, n_ey;
    logic signed [DW-1:0] r_e_x, r_e_y;
    logic signed [PW-1:0] r_sq_x, r_sq_y;

    logic [SW-1:0]        r_srem  [RW+1];
    logic [RW-1:0]        r_sroot [RW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wd_x <= i_w_x * i_d_x;
            r1_wd_y <= i_w_y * i_d_y;
            r1_dd_x <= i_d_x * i_d_x;
            r1_dd_y <= i_d_y * i_d_y;
            r1_ctx  <= '{w_x: i_w_x, w_y: i_w_y, d_x: i_d_x, d_y: i_d_y,
                         zero: 1'b0, one: 1'b0};
        end
    end

    always_comb begin
        n_len  = LW'(r1_dd_x[LW-2:0]) + LW'(r1_dd_y[LW-2:0]);
        n_dot  = r1_wd_x + r1_wd_y;
        n_zero = (n_len == '0) || n_dot[PW-1] || (n_dot == '0);
        n_one  = (n_dot[LW-1:0] >= n_len);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dctx[0] <= '{w_x: r1_ctx.w_x, w_y: r1_ctx.w_y,
                           d_x: r1_ctx.d_x, d_y: r1_ctx.d_y,
                           zero: n_zero, one: n_one};
            r_dlen[0] <= n_len;
            r_drem[0] <= n_dot[LW-1:0];
            r_dq[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < TFB; k++) begin : g_div
        logic [LW:0] sh;
        logic [LW:0] diff;
        logic        ge;

        assign sh   = {r_drem[k], 1'b0};
        assign ge   = (sh >= {1'b0, r_dlen[k]});
        assign diff = sh - {1'b0, r_dlen[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[k+1] <= ge ? diff[LW-1:0] : sh[LW-1:0];
                r_dq[k+1]   <= {r_dq[k][TFB-2:0], ge};
                r_dlen[k+1] <= r_dlen[k];
                r_dctx[k+1] <= r_dctx[k];
            end
        end
    end

    always_comb begin
        if (r_dctx[TFB].zero) begin
            n_t = '0;
        end else if (r_dctx[TFB].one) begin
            n_t = TW'(1) << TFB;
        end else begin
            n_t = {1'b0, r_dq[TFB]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_x  <= mag(r_dctx[TFB].d_x) * n_t;
            r_p_y  <= mag(r_dctx[TFB].d_y) * n_t;
            r_pctx <= r_dctx[TFB];
        end
    end

    always_comb begin
        off_x = r_p_x[TFB +: CW];
        off_y = r_p_y[TFB +: CW];
        n_ex  = {r_pctx.w_x[DW-1], r_pctx.w_x}
              - (r_pctx.d_x[DW-1] ? -$signed({2'b00, off_x}) : $signed({2'b00, off_x}));
        n_ey  = {r_pctx.w_y[DW-1], r_pctx.w_y}
              - (r_pctx.d_y[DW-1] ? -$signed({2'b00, off_y}) : $signed({2'b00, off_y}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_x      <= n_ex[DW-1:0];
            r_e_y      <= n_ey[DW-1:0];
            r_sq_x     <= r_e_x * r_e_x;
            r_sq_y     <= r_e_y * r_e_y;
            r_srem[0]  <= SW'(r_sq_x[LW-2:0]) + SW'(r_sq_y[LW-2:0]);
            r_sroot[0] <= '0;
        end
    end

    // floor square root, one root bit per stage from the top
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int B = RW - 1 - j;
        logic [SW-1:0] inc;
        logic          ge;

        assign inc = (SW'(r_sroot[j]) << (B + 1)) | (SW'(1) << (2 * B));
        assign ge  = (r_srem[j] >= inc);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[j+1]  <= ge ? (r_srem[j] - inc) : r_srem[j];
                r_sroot[j+1] <= ge ? (r_sroot[j] | (RW'(1) << B)) : r_sroot[j];
            end
        end
    end

    assign o_dist = r_sroot[RW];

endmodule

// ===== hdl/csc_back.sv =====
// ----------------------------------------------------------------------------
// csc_back
// Execution pipeline: four distance lanes, crossing test, minimum and gap.
// ----------------------------------------------------------------------------
module csc_back #(
    parameter int T_FRACTION_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csc_pkg::t_item     i_item,
    input  logic               i_item_valid,
    output logic               o_item_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output csc_pkg::t_result   o_res
);

    localparam int LAT = T_FRACTION_BITS + csc_pkg::LANE_FIXED;
    localparam int DW  = csc_pkg::DIFF_W;
    localparam int PW  = csc_pkg::PROD_W;
    localparam int RW  = csc_pkg::DIST_W;

    logic                 adv;
    logic signed [DW-1:0] wx [4];
    logic signed [DW-1:0] wy [4];
    logic signed [DW-1:0] sx [4];
    logic signed [DW-1:0] sy [4];
    logic [RW-1:0]        lane_dist [4];

    logic signed [PW-1:0] r_op_a [4];
    logic signed [PW-1:0] r_op_b [4];
    logic                 r_oneg [4];
    logic                 r_opos [4];
    logic                 n_cross;
    csc_pkg::t_side       n_side2;

    csc_pkg::t_side       r_side [LAT];
    logic                 r_v    [LAT];

    logic [RW-1:0]        r_m01, r_m23, r_dist;
    csc_pkg::t_side       r_mside, r_fside;
    logic                 r_mv, r_fv;

    logic signed [RW+1:0] gap;

    // pipeline moves only while the result queue has room
    assign adv        = !i_res_full;
    assign o_item_pop = adv && i_item_valid;

    always_comb begin
        wx[0] = i_item.w0_x;   wy[0] = i_item.w0_y;
        wx[1] = i_item.w1_x;   wy[1] = i_item.w1_y;
        wx[2] = -i_item.w0_x;  wy[2] = -i_item.w0_y;
        wx[3] = i_item.w3_x;   wy[3] = i_item.w3_y;
        sx[0] = i_item.d2_x;   sy[0] = i_item.d2_y;
        sx[1] = i_item.d2_x;   sy[1] = i_item.d2_y;
        sx[2] = i_item.d1_x;   sy[2] = i_item.d1_y;
        sx[3] = i_item.d1_x;   sy[3] = i_item.d1_y;
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic signed [PW-1:0] od;

        csc_lane #(
            .T_FRACTION_BITS(T_FRACTION_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_w_x  (wx[k]),
            .i_w_y  (wy[k]),
            .i_d_x  (sx[k]),
            .i_d_y  (sy[k]),
            .o_dist (lane_dist[k])
        );

        // orientation of the point against the other segment
        assign od = r_op_a[k] - r_op_b[k];

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_op_a[k] <= sx[k] * wy[k];
                r_op_b[k] <= sy[k] * wx[k];
                r_oneg[k] <= od[PW-1];
                r_opos[k] <= !od[PW-1] && (od != '0);
            end
        end
    end

    assign n_cross = ((r_opos[0] && r_oneg[1]) || (r_oneg[0] && r_opos[1]))
                  && ((r_opos[2] && r_oneg[3]) || (r_oneg[2] && r_opos[3]));

    // crossing flag is ready two stages in
    always_comb begin
        n_side2         = r_side[1];
        n_side2.crossed = n_cross;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_v[k] <= 1'b0;
            end
            r_mv <= 1'b0;
            r_fv <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_item_valid;
            for (int k = 1; k < LAT; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_mv <= r_v[LAT-1];
            r_fv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= '{eff: i_item.eff, r1: i_item.r1, r2: i_item.r2, crossed: 1'b0};
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= (k == 2) ? n_side2 : r_side[k-1];
            end
            r_m01   <= (lane_dist[1] < lane_dist[0]) ? lane_dist[1] : lane_dist[0];
            r_m23   <= (lane_dist[3] < lane_dist[2]) ? lane_dist[3] : lane_dist[2];
            r_mside <= r_side[LAT-1];
            r_dist  <= r_mside.crossed ? '0 : ((r_m23 < r_m01) ? r_m23 : r_m01);
            r_fside <= r_mside;
        end
    end

    assign gap = $signed((RW+2)'(r_dist)) - $signed((RW+2)'(r_fside.r1))
               - $signed((RW+2)'(r_fside.r2));

    always_comb begin
        o_res.eff       = r_fside.eff;
        o_res.violation = gap < $signed((RW+2)'(r_fside.eff));
        o_res.gap       = gap[RW+1] ? '0 : gap[csc_pkg::GAP_W-1:0];
    end

    assign o_res_push = r_fv && adv;

endmodule

// ===== hdl/capsule_pair_clearance_check_top.sv =====
// ----------------------------------------------------------------------------
// capsule_pair_clearance_check_top
// Clearance check between two copper capsules (segment plus radius).
// ----------------------------------------------------------------------------
// Usage:
// - input channel: drive the twelve capsule fields and push; a transfer
//   happens on a clock edge with push high and full low
// - result channel: while empty is low the oldest result (violation,
//   clamped gap, effective clearance) is on the outputs; pop takes it
// - i_cfg_we writes i_cfg_wdata into the global minimum clearance; write it
//   only while no item is in flight
// - one item per cycle sustained while pop keeps the result queue from
//   filling; the pipeline depth is set by the quotient stages of the t divider
//   and one stage per square root bit in each distance lane
// - a small queue parts the input stage from the lanes, and another holds
//   results; when pop stays low the lanes freeze, the queues fill and full
//   rises after the front stage is also taken
// - synchronous reset empties both queues and the pipeline and loads the
//   global clearance with 200000 nm
// ----------------------------------------------------------------------------
module capsule_pair_clearance_check_top #(
    parameter int T_FRACTION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [csc_pkg::CLR_W-1:0]           i_cfg_wdata,
    input  logic                                push,
    output logic                                full,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_first_start_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_first_start_y,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_first_end_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_first_end_y,
    input  logic [csc_pkg::RAD_W-1:0]           i_first_radius,
    input  logic [csc_pkg::CLR_W-1:0]           i_first_class_clearance,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_second_start_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_second_start_y,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_second_end_x,
    input  logic signed [csc_pkg::COORD_W-1:0]  i_second_end_y,
    input  logic [csc_pkg::RAD_W-1:0]           i_second_radius,
    input  logic [csc_pkg::CLR_W-1:0]           i_second_class_clearance,
    input  logic                                pop,
    output logic                                empty,
    output logic                                o_violation,
    output logic [csc_pkg::GAP_W-1:0]           o_gap_clamped,
    output logic [csc_pkg::CLR_W-1:0]           o_effective_clearance
);

    localparam int ITEM_W = $bits(csc_pkg::t_item);
    localparam int RES_W  = $bits(csc_pkg::t_result);

    csc_pkg::t_item   front_item;
    logic             front_valid;
    logic             mid_full;
    logic             mid_empty;
    csc_pkg::t_item   mid_item;
    logic             mid_pop;
    logic             res_full;
    logic             res_push;
    csc_pkg::t_result back_res;
    csc_pkg::t_result head_res;

    csc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .o_full       (full),
        .i_a1_x       (i_first_start_x),
        .i_a1_y       (i_first_start_y),
        .i_b1_x       (i_first_end_x),
        .i_b1_y       (i_first_end_y),
        .i_r1         (i_first_radius),
        .i_c1         (i_first_class_clearance),
        .i_a2_x       (i_second_start_x),
        .i_a2_y       (i_second_start_y),
        .i_b2_x       (i_second_end_x),
        .i_b2_y       (i_second_end_y),
        .i_r2         (i_second_radius),
        .i_c2         (i_second_class_clearance),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_full  (mid_full)
    );

    csc_fifo2 #(
        .WIDTH(ITEM_W)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_item),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_item),
        .o_empty (mid_empty)
    );

    csc_back #(
        .T_FRACTION_BITS(T_FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (mid_item),
        .i_item_valid (!mid_empty),
        .o_item_pop   (mid_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (back_res)
    );

    csc_fifo2 #(
        .WIDTH(RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_res),
        .o_empty (empty)
    );

    assign o_violation           = head_res.violation;
    assign o_gap_clamped         = head_res.gap;
    assign o_effective_clearance = head_res.eff;

endmodule

// ===== hdl/csc_check.sv =====
// ----------------------------------------------------------------------------
// csc_check
// Port-level checks of the capsule clearance check, bound to the top level.
// ----------------------------------------------------------------------------
module csc_check (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      pop,
    input logic                      empty,
    input logic                      o_violation,
    input logic [csc_pkg::GAP_W-1:0] o_gap_clamped,
    input logic [csc_pkg::CLR_W-1:0] o_effective_clearance
);

    logic [csc_pkg::GAP_W-1:0] eff_ext;

    assign eff_ext = csc_pkg::GAP_W'(o_effective_clearance);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_head_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_gap_clamped)
            && $stable(o_violation) && $stable(o_effective_clearance))
        else $error("waiting result changed");

    // a nonzero gap or clearance fixes the flag from the visible fields
    a_flag_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_gap_clamped != '0 || o_effective_clearance != '0)
            |-> o_violation == (o_gap_clamped < eff_ext))
        else $error("violation flag disagrees with gap and clearance");

    a_full_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without an input transfer");

endmodule

bind capsule_pair_clearance_check_top csc_check u_csc_check (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .push                  (push),
    .full                  (full),
    .pop                   (pop),
    .empty                 (empty),
    .o_violation           (o_violation),
    .o_gap_clamped         (o_gap_clamped),
    .o_effective_clearance (o_effective_clearance)
);
